// ----- hw/rtl/csr_pkg.sv -----
// Shared constants, types and the square root step for the complex square root block.
package csr_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int IN_W          = 32;
  localparam int OUT_RE_W      = 24;
  localparam int OUT_IM_W      = 25;
  localparam int SQ_W          = 64;
  localparam int MAG_STEPS     = 32;
  localparam int HALF_W        = IN_W + FRACTION_BITS;
  localparam int HALF_STEPS    = (HALF_W + 1) / 2;
  localparam int HALF_PAD_W    = 2 * HALF_STEPS;
  localparam int ROOT_W        = 32;
  localparam int REM_W         = ROOT_W + 2;
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 56;

  localparam logic [OUT_RE_W-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
  } sqrt_st_t;

  typedef struct packed {
    logic [IN_W-1:0] ax;
    logic            xneg;
    logic            yneg;
  } side_t;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] d);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] trial;
    sqrt_st_t         o;
    r2    = {s.rem, d};
    trial = {{(REM_W - ROOT_W){1'b0}}, s.q, 2'b01};
    if (r2 >= trial) begin
      o.rem = REM_W'(r2 - trial);
      o.q   = {s.q[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = r2[REM_W-1:0];
      o.q   = {s.q[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- hw/rtl/csr_mag.sv -----
// Magnitude pipeline: absolute values, squares, sum and a bit-per-stage integer root.
module csr_mag
  import csr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   re_part,
  input  logic [IN_W-1:0]   im_part,
  output logic              mag_valid,
  output logic [ROOT_W-1:0] mag,
  output side_t             mag_side
);

  logic              va_r, vb_r, vc_r;
  side_t             sa_r, sb_r, sc_r;
  logic [IN_W-1:0]   ay_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sum_r;

  logic              v_r    [MAG_STEPS];
  side_t             side_r [MAG_STEPS];
  sqrt_st_t          st_r   [MAG_STEPS];
  logic [SQ_W-1:0]   rad_r  [MAG_STEPS];
  sqrt_st_t          st_nxt [MAG_STEPS];
  logic [SQ_W-1:0]   rad_nxt[MAG_STEPS];

  always_comb begin
    st_nxt[0]  = sqrt_step('0, sum_r[SQ_W-1 -: 2]);
    rad_nxt[0] = sum_r << 2;
    for (int i = 1; i < MAG_STEPS; i++) begin
      st_nxt[i]  = sqrt_step(st_r[i-1], rad_r[i-1][SQ_W-1 -: 2]);
      rad_nxt[i] = rad_r[i-1] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      for (int i = 0; i < MAG_STEPS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      va_r   <= in_valid;
      vb_r   <= va_r;
      vc_r   <= vb_r;
      v_r[0] <= vc_r;
      for (int i = 1; i < MAG_STEPS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r.ax   <= re_part[IN_W-1] ? (~re_part + 32'd1) : re_part;
      sa_r.xneg <= re_part[IN_W-1];
      sa_r.yneg <= im_part[IN_W-1];
      ay_r      <= im_part[IN_W-1] ? (~im_part + 32'd1) : im_part;
      sqx_r     <= SQ_W'(sa_r.ax) * SQ_W'(sa_r.ax);
      sqy_r     <= SQ_W'(ay_r) * SQ_W'(ay_r);
      sb_r      <= sa_r;
      sum_r     <= sqx_r + sqy_r;
      sc_r      <= sb_r;
      side_r[0] <= sc_r;
      for (int i = 0; i < MAG_STEPS; i++) begin
        st_r[i]  <= st_nxt[i];
        rad_r[i] <= rad_nxt[i];
      end
      for (int i = 1; i < MAG_STEPS; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign mag_valid = v_r[MAG_STEPS-1];
  assign mag       = st_r[MAG_STEPS-1].q;
  assign mag_side  = side_r[MAG_STEPS-1];

endmodule

// ----- hw/rtl/csr_half.sv -----
// Half-sum stage and the two parallel root pipelines for the real and imaginary parts.
module csr_half
  import csr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              mag_valid,
  input  logic [ROOT_W-1:0] mag,
  input  side_t             mag_side,
  output logic              root_valid,
  output logic [ROOT_W-1:0] re_root,
  output logic [ROOT_W-1:0] im_root,
  output logic              root_yneg
);

  logic                  vab_r, yab_r;
  logic [ROOT_W-1:0]     a_r, b_r;
  logic [ROOT_W:0]       hsum;
  logic [ROOT_W-1:0]     hdiff;
  logic [HALF_PAD_W-1:0] a_rad, b_rad;

  logic                  v_r     [HALF_STEPS];
  logic                  yneg_r  [HALF_STEPS];
  sqrt_st_t              re_st_r [HALF_STEPS];
  sqrt_st_t              im_st_r [HALF_STEPS];
  logic [HALF_PAD_W-1:0] re_rad_r[HALF_STEPS];
  logic [HALF_PAD_W-1:0] im_rad_r[HALF_STEPS];
  sqrt_st_t              re_st_nxt [HALF_STEPS];
  sqrt_st_t              im_st_nxt [HALF_STEPS];
  logic [HALF_PAD_W-1:0] re_rad_nxt[HALF_STEPS];
  logic [HALF_PAD_W-1:0] im_rad_nxt[HALF_STEPS];

  assign hsum  = {1'b0, mag} + {1'b0, mag_side.ax};
  assign hdiff = mag - mag_side.ax;
  assign a_rad = HALF_PAD_W'({a_r, {FRACTION_BITS{1'b0}}});
  assign b_rad = HALF_PAD_W'({b_r, {FRACTION_BITS{1'b0}}});

  always_comb begin
    re_st_nxt[0]  = sqrt_step('0, a_rad[HALF_PAD_W-1 -: 2]);
    im_st_nxt[0]  = sqrt_step('0, b_rad[HALF_PAD_W-1 -: 2]);
    re_rad_nxt[0] = a_rad << 2;
    im_rad_nxt[0] = b_rad << 2;
    for (int i = 1; i < HALF_STEPS; i++) begin
      re_st_nxt[i]  = sqrt_step(re_st_r[i-1], re_rad_r[i-1][HALF_PAD_W-1 -: 2]);
      im_st_nxt[i]  = sqrt_step(im_st_r[i-1], im_rad_r[i-1][HALF_PAD_W-1 -: 2]);
      re_rad_nxt[i] = re_rad_r[i-1] << 2;
      im_rad_nxt[i] = im_rad_r[i-1] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vab_r <= 1'b0;
      for (int i = 0; i < HALF_STEPS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vab_r  <= mag_valid;
      v_r[0] <= vab_r;
      for (int i = 1; i < HALF_STEPS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r       <= mag_side.xneg ? (hdiff >> 1) : hsum[ROOT_W:1];
      b_r       <= mag_side.xneg ? hsum[ROOT_W:1] : (hdiff >> 1);
      yab_r     <= mag_side.yneg;
      yneg_r[0] <= yab_r;
      for (int i = 0; i < HALF_STEPS; i++) begin
        re_st_r[i]  <= re_st_nxt[i];
        im_st_r[i]  <= im_st_nxt[i];
        re_rad_r[i] <= re_rad_nxt[i];
        im_rad_r[i] <= im_rad_nxt[i];
      end
      for (int i = 1; i < HALF_STEPS; i++) begin
        yneg_r[i] <= yneg_r[i-1];
      end
    end
  end

  assign root_valid = v_r[HALF_STEPS-1];
  assign re_root    = re_st_r[HALF_STEPS-1].q;
  assign im_root    = im_st_r[HALF_STEPS-1].q;
  assign root_yneg  = yneg_r[HALF_STEPS-1];

endmodule

// ----- hw/rtl/complex_square_root_top.sv -----
// Principal complex square root, fixed point, fully pipelined.
// Takes one item per cycle unless the pipeline holds, and returns one result per item,
// in order, through the absolute-value, square and sum registers, the one-bit-per-stage
// root pipelines (32 stages for the magnitude; a half-sum stage, then one stage per root
// bit for the two parallel half-sum roots) and an output register. The whole pipeline
// holds while an output waits and out_tready is low, and in_tready follows it.
module complex_square_root_top
  import csr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // re_part[31:0], im_part[63:32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // sqrt_real[23:0], sqrt_imag[48:24], zero pad
);

  logic              adv;
  logic              mag_valid;
  logic [ROOT_W-1:0] mag;
  side_t             mag_side;
  logic              root_valid;
  logic [ROOT_W-1:0] re_root, im_root;
  logic              root_yneg;
  logic [OUT_RE_W-1:0] re_sat, im_sat;
  logic [OUT_IM_W-1:0] im_nxt;

  logic                out_valid_r;
  logic [OUT_RE_W-1:0] sqrt_real_r;
  logic [OUT_IM_W-1:0] sqrt_imag_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  csr_mag u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .re_part   (in_tdata[IN_W-1:0]),
    .im_part   (in_tdata[2*IN_W-1:IN_W]),
    .mag_valid (mag_valid),
    .mag       (mag),
    .mag_side  (mag_side)
  );

  csr_half u_half (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .mag_valid  (mag_valid),
    .mag        (mag),
    .mag_side   (mag_side),
    .root_valid (root_valid),
    .re_root    (re_root),
    .im_root    (im_root),
    .root_yneg  (root_yneg)
  );

  assign re_sat = (re_root > ROOT_W'(OUT_MAX)) ? OUT_MAX : re_root[OUT_RE_W-1:0];
  assign im_sat = (im_root > ROOT_W'(OUT_MAX)) ? OUT_MAX : im_root[OUT_RE_W-1:0];
  assign im_nxt = root_yneg ? (~{1'b0, im_sat} + 25'd1) : {1'b0, im_sat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && root_valid) begin
      sqrt_real_r <= re_sat;
      sqrt_imag_r <= im_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({sqrt_imag_r, sqrt_real_r});

endmodule
